// ===== rtl/hfie_pkg.sv =====
package hfie_pkg;

  localparam int STORE_WORDS_DEF = 65536;
  localparam int SUM_BITS_DEF    = 32;

  localparam int FEAT_W      = 36;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;
  localparam int ADDR_W      = 28;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 3'd5;

  typedef enum logic [1:0] {
    KIND_HALF_H  = 2'd0,
    KIND_HALF_V  = 2'd1,
    KIND_THIRD_H = 2'd2,
    KIND_THIRD_V = 2'd3
  } kind_t;

  localparam logic [3:0] STEP_LAST2 = 4'd7;
  localparam logic [3:0] STEP_LAST3 = 4'd11;

  localparam logic [11:0] DIV3_MUL   = 12'd2731;
  localparam int          DIV3_SHIFT = 13;

  // floor(v/3) for v < 2048 by reciprocal multiply
  function automatic logic [10:0] div3(input logic [10:0] v);
    logic [23:0] p;
    p = 24'(v) * 24'(DIV3_MUL);
    return p[DIV3_SHIFT +: 11];
  endfunction

endpackage

// ===== rtl/haar_feature_integral_eval.sv =====
// Channel  Dir  Handshake              Contents
// s_axis   in   s_axis_tvalid/tready   load word or evaluate at window origin
// m_axis   out  m_axis_tvalid/tready   feature response and out-of-range flag
// cfg      in   cfg_we                 geometry and row pitch registers
//
// A load writes at most one store word; an evaluate reads the four corners
// of each of two rectangles (halves) or three (thirds), one corner read per
// cycle on the single store port while the pipeline is not stalled.
// Items follow back to back unless the pipeline stalls. rst is synchronous;
// the store is not cleared.
// A result that waits on m_axis_tready freezes the pipeline once the next
// result is ready to leave.
module haar_feature_integral_eval
  import hfie_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // load_address[15:0], load_word[47:16], window_x[57:48], window_y[67:58]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // feature_value[35:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // out_of_range[0]
  output logic                   m_axis_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW       = $clog2(STORE_WORDS);
  localparam int ACC_BITS = SUM_BITS + 5;
  localparam int CMP_W    = (ACC_BITS > FEAT_W) ? ACC_BITS : FEAT_W;
  localparam logic signed [ADDR_W-1:0] STORE_LIMIT = ADDR_W'(STORE_WORDS);
  localparam logic signed [CMP_W-1:0] SAT_HI =
    {{(CMP_W-FEAT_W+1){1'b0}}, {(FEAT_W-1){1'b1}}};
  localparam logic signed [CMP_W-1:0] SAT_LO =
    {{(CMP_W-FEAT_W+1){1'b1}}, {(FEAT_W-1){1'b0}}};

  // configuration
  kind_t       feature_kind;
  logic [9:0]  feature_left, feature_top, feature_width, feature_height;
  logic [10:0] row_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_kind   <= KIND_HALF_H;
      feature_left   <= '0;
      feature_top    <= '0;
      feature_width  <= '0;
      feature_height <= '0;
      row_pitch      <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND:   feature_kind   <= kind_t'(cfg_data[1:0]);
        CFG_LEFT:   feature_left   <= cfg_data[9:0];
        CFG_TOP:    feature_top    <= cfg_data[9:0];
        CFG_WIDTH:  feature_width  <= cfg_data[9:0];
        CFG_HEIGHT: feature_height <= cfg_data[9:0];
        CFG_PITCH:  row_pitch      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // derived geometry, registered from the configuration registers
  logic [9:0] w3, w23, h3, h23;

  always_ff @(posedge clk) begin
    w3  <= 10'(div3({1'b0, feature_width}));
    w23 <= 10'(div3({feature_width, 1'b0}));
    h3  <= 10'(div3({1'b0, feature_height}));
    h23 <= 10'(div3({feature_height, 1'b0}));
  end

  logic [9:0] w2, h2;
  assign w2 = {1'b0, feature_width[9:1]};
  assign h2 = {1'b0, feature_height[9:1]};

  logic adv;
  logic fin;
  logic out_valid;

  // stage 0: sequencer
  logic        s0_busy, s0_eval;
  logic [3:0]  step;
  logic [10:0] s0_x, s0_y;
  logic [15:0] s0_ld_addr;
  logic [31:0] s0_ld_word;
  logic        s0_last;
  logic        in_take;

  assign s0_last = !s0_eval ||
    (step == ((feature_kind == KIND_THIRD_H || feature_kind == KIND_THIRD_V) ?
              STEP_LAST3 : STEP_LAST2));
  assign s_axis_tready = adv && (!s0_busy || s0_last);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_busy <= 1'b0;
      step    <= '0;
    end else if (adv) begin
      if (in_take) begin
        s0_busy <= 1'b1;
        step    <= '0;
      end else if (s0_busy && s0_last) begin
        s0_busy <= 1'b0;
      end else if (s0_busy) begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_take) begin
      s0_eval    <= (s_axis_tuser == CMD_EVAL);
      s0_ld_addr <= s_axis_tdata[15:0];
      s0_ld_word <= s_axis_tdata[47:16];
      s0_x       <= 11'(s_axis_tdata[57:48]) + 11'(feature_left);
      s0_y       <= 11'(s_axis_tdata[67:58]) + 11'(feature_top);
    end
  end

  // rectangle and corner of the current step
  logic [10:0] dx, dy;
  logic [9:0]  iw, ih;
  logic        rect_neg;

  always_comb begin
    dx       = '0;
    dy       = '0;
    iw       = feature_width;
    ih       = feature_height;
    rect_neg = 1'b1;
    unique case (feature_kind)
      KIND_HALF_H: begin
        iw = w2;
        if (step[3:2] == 2'd0) begin
          dx       = 11'(w2);
          rect_neg = 1'b0;
        end
      end
      KIND_HALF_V: begin
        ih = h2;
        if (step[3:2] == 2'd0) begin
          rect_neg = 1'b0;
        end else begin
          dy = 11'(h2);
        end
      end
      KIND_THIRD_H: begin
        iw = w3;
        unique case (step[3:2])
          2'd0: begin
            dx       = 11'(w3);
            rect_neg = 1'b0;
          end
          2'd1: dx = '0;
          default: dx = 11'(w23);
        endcase
      end
      KIND_THIRD_V: begin
        ih = h3;
        unique case (step[3:2])
          2'd0: begin
            dy       = 11'(h3);
            rect_neg = 1'b0;
          end
          2'd1: dy = '0;
          default: dy = 11'(h23);
        endcase
      end
    endcase
  end

  logic [11:0]        px, py;
  logic signed [13:0] row_far, row_near, col_far, col_near;
  logic signed [13:0] t_row, t_col;
  logic               t_neg, t_use;

  assign px       = 12'(s0_x) + 12'(dx);
  assign py       = 12'(s0_y) + 12'(dy);
  assign row_far  = 14'(py) + 14'(ih) - 14'd1;
  assign row_near = 14'(py) - 14'd1;
  assign col_far  = 14'(px) + 14'(iw) - 14'd1;
  assign col_near = 14'(px) - 14'd1;

  always_comb begin
    unique case (step[1:0])
      2'd0: begin
        t_row = row_far;  t_col = col_far;  t_neg = rect_neg;
        t_use = 1'b1;
      end
      2'd1: begin
        t_row = row_far;  t_col = col_near; t_neg = !rect_neg;
        t_use = (px != '0);
      end
      2'd2: begin
        t_row = row_near; t_col = col_far;  t_neg = !rect_neg;
        t_use = (py != '0);
      end
      default: begin
        t_row = row_near; t_col = col_near; t_neg = rect_neg;
        t_use = (px != '0) && (py != '0);
      end
    endcase
  end

  // stage 1: address
  logic               s1_vld, s1_eval, s1_neg, s1_use, s1_first, s1_last;
  logic signed [13:0] s1_row, s1_col;
  logic [15:0]        s1_ld_addr;
  logic [31:0]        s1_ld_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_eval    <= s0_eval;
      s1_row     <= t_row;
      s1_col     <= t_col;
      s1_neg     <= t_neg;
      s1_use     <= t_use;
      s1_first   <= (step == '0);
      s1_last    <= s0_last;
      s1_ld_addr <= s0_ld_addr;
      s1_ld_word <= s0_ld_word;
    end
  end

  logic signed [11:0]       pitch_s;
  logic signed [25:0]       prod;
  logic signed [ADDR_W-1:0] addr_wide;
  logic                     in_range;

  assign pitch_s   = $signed({1'b0, row_pitch});
  assign prod      = s1_row * pitch_s;
  assign addr_wide = s1_eval ? (ADDR_W'(prod) + ADDR_W'(s1_col))
                             : $signed(ADDR_W'(s1_ld_addr));
  assign in_range  = !addr_wide[ADDR_W-1] && (addr_wide < STORE_LIMIT);

  // stage 2: store access
  logic                s2_vld, s2_eval, s2_we, s2_use, s2_bad;
  logic                s2_neg, s2_first, s2_last;
  logic [AW-1:0]       s2_addr;
  logic [SUM_BITS-1:0] s2_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_eval  <= s1_eval;
      s2_we    <= !s1_eval && in_range;
      s2_use   <= s1_use;
      s2_bad   <= s1_eval && s1_use && !in_range;
      s2_neg   <= s1_neg;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_addr  <= addr_wide[AW-1:0];
      s2_word  <= SUM_BITS'(s1_ld_word);
    end
  end

  logic [SUM_BITS-1:0] store [STORE_WORDS];
  logic [SUM_BITS-1:0] rdata;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s2_vld && s2_we) begin
        store[s2_addr] <= s2_word;
      end
      rdata <= store[s2_addr];
    end
  end

  // stage 3: accumulate
  logic s3_vld, s3_eval, s3_use, s3_bad, s3_neg, s3_first, s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_eval  <= s2_eval;
      s3_use   <= s2_use;
      s3_bad   <= s2_bad;
      s3_neg   <= s2_neg;
      s3_first <= s2_first;
      s3_last  <= s2_last;
    end
  end

  logic signed [ACC_BITS-1:0] acc, term, acc_base, acc_sum;
  logic                       bad_acc;

  assign term     = (s3_use && !s3_bad) ? $signed(ACC_BITS'(rdata)) : '0;
  assign acc_base = s3_first ? '0 : acc;
  assign acc_sum  = s3_neg ? (acc_base - term) : (acc_base + term);

  always_ff @(posedge clk) begin
    if (adv && s3_vld && s3_eval) begin
      acc     <= acc_sum;
      bad_acc <= (s3_first ? 1'b0 : bad_acc) | s3_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else if (adv) begin
      fin <= s3_vld && s3_eval && s3_last;
    end
  end

  // stage 4: saturate into the output register
  logic signed [CMP_W-1:0]  acc_ext;
  logic signed [FEAT_W-1:0] feat_sat;

  assign acc_ext = CMP_W'(acc);

  always_comb begin
    priority if (bad_acc) begin
      feat_sat = '0;
    end else if (acc_ext > SAT_HI) begin
      feat_sat = FEAT_W'(SAT_HI);
    end else if (acc_ext < SAT_LO) begin
      feat_sat = FEAT_W'(SAT_LO);
    end else begin
      feat_sat = FEAT_W'(acc_ext);
    end
  end

  assign adv = !(fin && out_valid && !m_axis_tready);

  logic [FEAT_W-1:0] out_feat;
  logic              out_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin && adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && adv) begin
      out_feat <= feat_sat;
      out_flag <= bad_acc;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_feat);
  assign m_axis_tuser  = out_flag;

`ifndef SYNTHESIS
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[FEAT_W-1:0] == '0))
    else $error("flagged result carries a nonzero value");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    s0_busy |-> (step <= STEP_LAST3))
    else $error("corner step beyond last corner");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(step) && $stable(s0_busy)))
    else $error("sequencer moved during output stall");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(fin))
    else $error("result raised without a finished evaluation");
`endif

endmodule
